@@ hw/rtl/swmv_pkg.sv @@
// Shared types and constants for the sliding window mean/variance block.
package swmv_pkg;

	localparam int VAR_W = 32;

	localparam logic OP_ADD   = 1'b0;
	localparam logic OP_CLEAR = 1'b1;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_READ,
		ST_OLDSQ,
		ST_UPDATE,
		ST_MEAN,
		ST_CORR_MUL,
		ST_CORR_DIV,
		ST_DIFF,
		ST_VAR,
		ST_OUT
	} state_t;

	typedef enum logic {
		ALU_MUL,
		ALU_DIV
	} alu_op_t;

	typedef struct packed {
		logic    start;
		alu_op_t op;
	} alu_ctl_t;

endpackage

@@ hw/rtl/swmv_ring.sv @@
// Sample ring memory: one write port, one registered read port.
module swmv_ring
	import swmv_pkg::*;
#(
	parameter int DEPTH = 256,
	parameter int W = 16,
	parameter int AW = $clog2(DEPTH)
)(
	input  logic          clk,
	input  logic          wr_en,
	input  logic [AW-1:0] wr_addr,
	input  logic [W-1:0]  wr_data,
	input  logic          rd_en,
	input  logic [AW-1:0] rd_addr,
	output logic [W-1:0]  rd_data
);

	logic [W-1:0] mem [DEPTH];
	logic [W-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

@@ hw/rtl/swmv_alu.sv @@
// Shared shift-add multiplier / restoring divider, one bit per cycle.
module swmv_alu
	import swmv_pkg::*;
#(
	parameter int W = 48,
	localparam int CW = $clog2(W + 1)
)(
	input  logic         clk,
	input  logic         arst_n,
	input  alu_ctl_t     ctl,
	input  logic [W-1:0] opa,
	input  logic [W-1:0] opb,
	output logic         done,
	output logic [W-1:0] result
);

	logic          busy_q;
	logic          done_q;
	alu_op_t       op_q;
	logic [CW-1:0] cnt_q;
	logic [W-1:0]  acc_q;
	logic [W-1:0]  x_q;
	logic [W-1:0]  y_q;
	logic [W-1:0]  rem_q;

	logic [W+1:0] add_a;
	logic [W+1:0] add_b;
	logic [W+1:0] add_r;
	logic         sub;
	logic         geq;

	// one adder serves both: acc + multiplicand, or shifted remainder - divisor
	always_comb begin
		sub = (op_q == ALU_DIV);
		if (sub) begin
			add_a = {1'b0, rem_q, x_q[W-1]};
			add_b = {2'b0, y_q};
		end else begin
			add_a = {2'b0, acc_q};
			add_b = {2'b0, x_q};
		end
		add_r = add_a + (sub ? ~add_b : add_b) + {{(W+1){1'b0}}, sub};
		geq   = ~add_r[W+1];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			op_q   <= ALU_MUL;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (ctl.start && !busy_q) begin
				busy_q <= 1'b1;
				op_q   <= ctl.op;
				cnt_q  <= (ctl.op == ALU_MUL) ? CW'(W / 2) : CW'(W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.start && !busy_q) begin
			acc_q <= '0;
			rem_q <= '0;
			x_q   <= opa;
			y_q   <= opb;
		end else if (busy_q) begin
			x_q <= {x_q[W-2:0], 1'b0};
			if (op_q == ALU_MUL) begin
				if (y_q[0]) begin
					acc_q <= add_r[W-1:0];
				end
				y_q <= {1'b0, y_q[W-1:1]};
			end else begin
				rem_q <= geq ? add_r[W-1:0] : add_a[W-1:0];
				acc_q <= {acc_q[W-2:0], geq};
			end
		end
	end

	assign done   = done_q;
	assign result = acc_q;

endmodule

@@ hw/rtl/sliding_window_mean_variance.sv @@
// Top level: sliding window mean and variance over a sample ring.
//
//  channel | dir | handshake                | payload
//  --------+-----+--------------------------+--------------------------------------
//  s_      | in  | s_tvalid / s_tready      | tdata: sample; tuser: opcode
//  m_      | out | m_tvalid / m_tready      | tdata: count, mean, variance;
//          |     |                          | tuser: variance_valid
//  cfg_    | in  | cfg_valid / cfg_ready    | cfg_data: window_length
//
// An add word runs through the shared one-bit-per-cycle multiply/divide unit,
// W = 2*(SAMPLE_WIDTH + log2 depth) bits wide (mean, square of the sum, two divisions).
// With fewer than two samples held it stops after the mean; a clear word goes
// straight to the output register.
// Reset empties the window and sets window_length to the ring depth; no clearing pass.
// A finished word waits in the output register; the next word is taken meanwhile.
module sliding_window_mean_variance
	import swmv_pkg::*;
#(
	parameter int WINDOW_DEPTH = 256,
	parameter int SAMPLE_WIDTH = 16,
	localparam int AW = $clog2(WINDOW_DEPTH),
	localparam int CNT_W = $clog2(WINDOW_DEPTH + 1),
	localparam int SUM_W = SAMPLE_WIDTH + AW,
	localparam int SQ_W = 2 * SAMPLE_WIDTH + AW,
	localparam int DIV_W = 2 * SUM_W,
	localparam int S_DATA_W = ((SAMPLE_WIDTH + 7) / 8) * 8,
	localparam int M_DATA_W = ((CNT_W + SAMPLE_WIDTH + VAR_W + 7) / 8) * 8
)(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	output logic                s_tready,
	input  logic [S_DATA_W-1:0] s_tdata,   // sample
	input  logic                s_tuser,   // opcode
	output logic                m_tvalid,
	input  logic                m_tready,
	output logic [M_DATA_W-1:0] m_tdata,   // count, mean, variance
	output logic                m_tuser,   // variance_valid
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [CNT_W-1:0]    cfg_data   // window_length
);

	localparam int SW = SAMPLE_WIDTH;
	localparam logic [DIV_W-1:0] HALF = {{(DIV_W-1){1'b0}}, 1'b1} << (SW - 1);

	state_t state_q, state_d;

	logic [CNT_W-1:0] win_len_q;
	logic [CNT_W-1:0] held_q;
	logic [AW-1:0]    wi_q;
	logic [SUM_W-1:0] sum_q;
	logic [SQ_W-1:0]  sq_q;
	logic             issued_q;
	logic             m_tvalid_q;

	logic                op_q;
	logic signed [SW-1:0] smp_q;
	logic [AW-1:0]       next_q;
	logic                drop_q;
	logic [2*SW-1:0]     new_sq_q;
	logic [2*SW-1:0]     old_sq_q;
	logic [DIV_W-1:0]    corr_q;
	logic [SW-1:0]       mean_q;
	logic [VAR_W-1:0]    var_q;
	logic [CNT_W-1:0]    cnt_o_q;
	logic [SW-1:0]       mean_o_q;
	logic [VAR_W-1:0]    var_o_q;
	logic                vvalid_o_q;

	logic [CNT_W-1:0] len_eff;
	logic [AW-1:0]    next_idx;
	logic             accept;
	logic             out_load;

	logic [SW-1:0]         rd_data;
	logic signed [SW-1:0]  mul_in;
	logic signed [2*SW-1:0] mul_p;

	alu_ctl_t         alu_ctl;
	logic [DIV_W-1:0] alu_a;
	logic [DIV_W-1:0] alu_b;
	logic             alu_done;
	logic [DIV_W-1:0] alu_res;

	logic [SUM_W-1:0]  neg_sum;
	logic [SUM_W-1:0]  mag;
	logic [SUM_W-1:0]  smp_ext;
	logic [SUM_W-1:0]  old_ext;
	logic [SW-1:0]     mean_n;
	logic [DIV_W:0]    sq_ext;
	logic [DIV_W:0]    diff;
	logic [DIV_W:0]    neg_diff;
	logic [DIV_W-1:0]  absd;
	logic [DIV_W+VAR_W-1:0] q_ext;
	logic [VAR_W-1:0]  var_n;

	// window length as used: zero acts as one, clipped to the ring depth
	always_comb begin
		if (win_len_q == '0) begin
			len_eff = CNT_W'(1);
		end else if (win_len_q > CNT_W'(WINDOW_DEPTH)) begin
			len_eff = CNT_W'(WINDOW_DEPTH);
		end else begin
			len_eff = win_len_q;
		end
		next_idx = (CNT_W'(wi_q) >= len_eff - 1'b1) ? '0 : wi_q + 1'b1;
	end

	assign s_tready  = (state_q == ST_IDLE);
	assign cfg_ready = 1'b1;
	assign accept    = s_tvalid && s_tready;
	assign out_load  = (state_q == ST_OUT) && (!m_tvalid_q || m_tready);

	// one multiplier squares the new sample, then the dropped one
	assign mul_in = (state_q == ST_READ) ? smp_q : $signed(rd_data);
	assign mul_p  = mul_in * mul_in;

	always_comb begin
		neg_sum  = ~sum_q + 1'b1;
		mag      = sum_q[SUM_W-1] ? neg_sum : sum_q;
		smp_ext  = {{(SUM_W-SW){smp_q[SW-1]}}, smp_q};
		old_ext  = {{(SUM_W-SW){rd_data[SW-1]}}, rd_data};
		sq_ext   = {{(DIV_W+1-SQ_W){sq_q[SQ_W-1]}}, sq_q};
		diff     = sq_ext - {1'b0, corr_q};
		neg_diff = ~diff + 1'b1;
		absd     = diff[DIV_W] ? neg_diff[DIV_W-1:0] : diff[DIV_W-1:0];

		// truncated quotient magnitude, sign restored, saturated to the sample range
		if (sum_q[SUM_W-1]) begin
			mean_n = (alu_res > HALF) ? {1'b1, {(SW-1){1'b0}}}
				: SW'(~alu_res[SW-1:0] + 1'b1);
		end else begin
			mean_n = (alu_res >= HALF) ? {1'b0, {(SW-1){1'b1}}} : alu_res[SW-1:0];
		end

		q_ext = {{VAR_W{1'b0}}, alu_res};
		var_n = (|q_ext[DIV_W+VAR_W-1:VAR_W]) ? '1 : q_ext[VAR_W-1:0];
	end

	always_comb begin
		state_d       = state_q;
		alu_ctl.start = 1'b0;
		alu_ctl.op    = ALU_MUL;
		alu_a         = '0;
		alu_b         = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (s_tvalid) begin
					state_d = (s_tuser == OP_CLEAR) ? ST_OUT : ST_READ;
				end
			end
			ST_READ:   state_d = ST_OLDSQ;
			ST_OLDSQ:  state_d = ST_UPDATE;
			ST_UPDATE: state_d = ST_MEAN;
			ST_MEAN: begin
				alu_ctl.start = !issued_q;
				alu_ctl.op    = ALU_DIV;
				alu_a         = DIV_W'(mag);
				alu_b         = DIV_W'(held_q);
				if (alu_done) begin
					state_d = (held_q >= CNT_W'(2)) ? ST_CORR_MUL : ST_OUT;
				end
			end
			ST_CORR_MUL: begin
				alu_ctl.start = !issued_q;
				alu_ctl.op    = ALU_MUL;
				alu_a         = DIV_W'(mag);
				alu_b         = DIV_W'(mag);
				if (alu_done) begin
					state_d = ST_CORR_DIV;
				end
			end
			ST_CORR_DIV: begin
				alu_ctl.start = !issued_q;
				alu_ctl.op    = ALU_DIV;
				alu_a         = corr_q;
				alu_b         = DIV_W'(held_q);
				if (alu_done) begin
					state_d = ST_DIFF;
				end
			end
			ST_DIFF: state_d = ST_VAR;
			ST_VAR: begin
				alu_ctl.start = !issued_q;
				alu_ctl.op    = ALU_DIV;
				alu_a         = corr_q;
				alu_b         = DIV_W'(held_q - 1'b1);
				if (alu_done) begin
					state_d = ST_OUT;
				end
			end
			ST_OUT: begin
				if (!m_tvalid_q || m_tready) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_len_q  <= CNT_W'(WINDOW_DEPTH);
			held_q     <= '0;
			wi_q       <= '0;
			sum_q      <= '0;
			sq_q       <= '0;
			issued_q   <= 1'b0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (cfg_valid) begin
				win_len_q <= cfg_data;
			end
			if (accept && s_tuser == OP_CLEAR) begin
				held_q <= '0;
				wi_q   <= '0;
				sum_q  <= '0;
				sq_q   <= '0;
			end
			if (state_q == ST_UPDATE) begin
				wi_q  <= next_q;
				sum_q <= sum_q + smp_ext - (drop_q ? old_ext : '0);
				sq_q  <= sq_q + SQ_W'(new_sq_q) - (drop_q ? SQ_W'(old_sq_q) : '0);
				if (!drop_q) begin
					held_q <= held_q + 1'b1;
				end
			end
			if (alu_done) begin
				issued_q <= 1'b0;
			end else if (alu_ctl.start) begin
				issued_q <= 1'b1;
			end
			if (out_load) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q   <= s_tuser;
			smp_q  <= $signed(s_tdata[SW-1:0]);
			next_q <= next_idx;
			drop_q <= (held_q >= len_eff);
			mean_q <= '0;
			var_q  <= '0;
		end
		if (state_q == ST_READ) begin
			new_sq_q <= mul_p;
		end
		if (state_q == ST_OLDSQ) begin
			old_sq_q <= mul_p;
		end
		if (state_q == ST_MEAN && alu_done) begin
			mean_q <= mean_n;
		end
		if ((state_q == ST_CORR_MUL || state_q == ST_CORR_DIV) && alu_done) begin
			corr_q <= alu_res;
		end
		if (state_q == ST_DIFF) begin
			corr_q <= absd;
		end
		if (state_q == ST_VAR && alu_done) begin
			var_q <= var_n;
		end
		if (out_load) begin
			cnt_o_q    <= held_q;
			mean_o_q   <= mean_q;
			var_o_q    <= var_q;
			vvalid_o_q <= (held_q >= CNT_W'(2));
		end
	end

	swmv_ring #(
		.DEPTH (WINDOW_DEPTH),
		.W     (SW),
		.AW    (AW)
	) u_ring (
		.clk     (clk),
		.wr_en   (state_q == ST_UPDATE),
		.wr_addr (next_q),
		.wr_data (smp_q),
		.rd_en   (state_q == ST_READ),
		.rd_addr (next_q),
		.rd_data (rd_data)
	);

	swmv_alu #(
		.W (DIV_W)
	) u_alu (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (alu_ctl),
		.opa    (alu_a),
		.opb    (alu_b),
		.done   (alu_done),
		.result (alu_res)
	);

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = M_DATA_W'({var_o_q, mean_o_q, cnt_o_q});
	assign m_tuser  = vvalid_o_q;

	// a done from the unit only answers an issued operation
	a_done_issued: assert property (@(posedge clk) disable iff (!arst_n)
		alu_done |-> issued_q)
		else $error("divider done without a pending operation");

	a_held_range: assert property (@(posedge clk) disable iff (!arst_n)
		held_q <= CNT_W'(WINDOW_DEPTH))
		else $error("held count beyond ring depth");

	a_clear_out: assert property (@(posedge clk) disable iff (!arst_n)
		(out_load && op_q == OP_CLEAR) |=> (m_tdata[CNT_W-1:0] == '0 && !m_tuser))
		else $error("clear word not reported as empty");

	a_vvalid_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser) |-> (m_tdata[CNT_W-1:0] >= CNT_W'(2)))
		else $error("variance flagged valid with fewer than two samples");

	a_idle_free: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready |-> !issued_q)
		else $error("ready while an operation is pending");

endmodule

@@ verif/swmv_checker.sv @@
// Checker for the sliding window mean/variance block: predicts each result word and compares.
module swmv_checker
	import swmv_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [15:0] s_tdata,    // sample
	input  logic        s_tuser,    // opcode
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [63:0] m_tdata,    // count, mean, variance
	input  logic        m_tuser,    // variance_valid
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic [8:0]  cfg_data,   // window_length
	output int          mismatches,
	output int          pending
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int     RING_DEPTH = 256;
	localparam longint VAR_CAP    = 64'h0000_0000_FFFF_FFFF;

	typedef struct packed {
		logic [8:0]  count;
		logic [15:0] mean;
		logic [31:0] variance;
		logic        var_ok;
	} stats_t;

	stats_t      stats_due[$];
	logic [15:0] ring [RING_DEPTH];
	logic [7:0]  wr_idx;
	logic [8:0]  held;
	logic [23:0] run_sum;
	logic [39:0] run_sq;
	logic [8:0]  win_len;
	int          miss_cnt = 0;

	assign mismatches = miss_cnt;

	// Updates the window for one input word and returns the statistics it reports.
	function automatic stats_t advance_window(input logic op, input logic [15:0] smp);
		stats_t r;
		int     len, nxt;
		longint v, old, acc, acc_sq, n, mean, mag, corr, diff, var_l;
		if (op == OP_CLEAR) begin
			run_sum = '0;
			run_sq  = '0;
			held    = '0;
			wr_idx  = '0;
		end else begin
			len = (win_len == 0) ? 1 : ((win_len > RING_DEPTH) ? RING_DEPTH : int'(win_len));
			nxt = (wr_idx >= len - 1) ? 0 : int'(wr_idx) + 1;
			v = longint'($signed(smp));
			acc = longint'($signed(run_sum));
			acc_sq = longint'($signed(run_sq));
			// full window (or shrunk length): the slot about to be written leaves the sums
			if (held >= len) begin
				old = longint'($signed(ring[nxt]));
				acc = acc - old;
				acc_sq = acc_sq - old * old;
			end else begin
				held = held + 1'b1;
			end
			wr_idx = 8'(nxt);
			ring[nxt] = smp;
			acc = acc + v;
			acc_sq = acc_sq + v * v;
			run_sum = acc[23:0];
			run_sq = acc_sq[39:0];
		end

		n = held;
		acc = longint'($signed(run_sum));
		acc_sq = longint'($signed(run_sq));
		mean = 0;
		if (n > 0) begin
			mean = acc / n;
			if (mean > 32767)
				mean = 32767;
			if (mean < -32768)
				mean = -32768;
		end
		var_l = 0;
		if (n >= 2) begin
			mag = (acc < 0) ? -acc : acc;
			corr = (mag * mag) / n;
			diff = acc_sq - corr;
			if (diff < 0)
				diff = -diff;
			var_l = diff / (n - 1);
			if (var_l > VAR_CAP)
				var_l = VAR_CAP;
		end
		r.count    = held;
		r.mean     = mean[15:0];
		r.variance = var_l[31:0];
		r.var_ok   = (n >= 2);
		return r;
	endfunction

	function automatic void report_miss(input string why, input stats_t want);
		if (miss_cnt < 10) begin
			$write("%0t %s: expected count=%0d mean=%0d var=%0d ok=%0b,",
				$realtime, why, want.count, $signed(want.mean), want.variance, want.var_ok);
			$display(" got count=%0d mean=%0d var=%0d ok=%0b pad=%0h",
				m_tdata[8:0], $signed(m_tdata[24:9]), m_tdata[56:25], m_tuser, m_tdata[63:57]);
		end
		miss_cnt++;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		stats_t want;
		if (!arst_n) begin
			stats_due.delete();
			wr_idx  = '0;
			held    = '0;
			run_sum = '0;
			run_sq  = '0;
			win_len = 9'd256;
			pending <= 0;
		end else begin
			// a result can never belong to a word taken on the same edge, so pop first
			if (m_tvalid && m_tready) begin
				if (stats_due.size() == 0) begin
					report_miss("result word with nothing pending", '0);
				end else begin
					want = stats_due.pop_front();
					if (m_tdata[8:0] != want.count || m_tdata[24:9] != want.mean ||
					    m_tdata[56:25] != want.variance || m_tuser != want.var_ok ||
					    m_tdata[63:57] != '0)
						report_miss("result word mismatch", want);
				end
			end
			if (cfg_valid && cfg_ready)
				win_len = cfg_data;
			if (s_tvalid && s_tready)
				stats_due.push_back(advance_window(s_tuser, s_tdata));
			pending <= stats_due.size();
		end
	end

endmodule

@@ verif/testbench.sv @@
// Testbench top: drives the sliding window mean/variance block and gives the verdict.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;
	import swmv_pkg::*;

	localparam int WATCH_LIMIT = 4000;

	logic        clk       = 1'b0;
	logic        arst_n    = 1'b0;
	logic        s_tvalid  = 1'b0;
	logic        s_tready;
	logic [15:0] s_tdata   = '0;    // sample
	logic        s_tuser   = OP_ADD; // opcode
	logic        m_tvalid;
	logic        m_tready  = 1'b0;
	logic [63:0] m_tdata;           // count, mean, variance
	logic        m_tuser;           // variance_valid
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [8:0]  cfg_data  = '0;    // window_length

	int mismatches;
	int pending;
	int quiet     = 0;
	int send_idle = 23;
	int recv_idle = 64;

	sliding_window_mean_variance dut (.*);

	swmv_checker check (.*);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	always @(posedge clk)
		m_tready <= ($urandom_range(99) >= recv_idle);

	// ends the run when nothing moves on any channel for too long
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
			quiet <= 0;
		else
			quiet <= quiet + 1;
		if (quiet >= WATCH_LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

	function automatic logic [15:0] pick_sample();
		case ($urandom_range(11))
			0:       return 16'h7FFF;
			1:       return 16'h8000;
			2:       return 16'h0000;
			3:       return 16'hFFFF;
			4, 5:    return 16'($signed(8'($urandom())));
			default: return 16'($urandom());
		endcase
	endfunction

	// leaves tvalid high after the word is taken; the caller lowers it or sends the next
	task automatic send_word(input logic op, input logic [15:0] smp);
		while ($urandom_range(99) < send_idle) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= op;
		s_tdata  <= smp;
		do @(posedge clk); while (!s_tready);
	endtask

	task automatic set_window(input logic [8:0] len);
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= len;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
	endtask

	initial begin
		logic [8:0] len_sel;
		int         words;
		int         clear_odds;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// extremes at the reset length, clear on an empty and on a non-empty window
		send_word(OP_CLEAR, 16'hA5A5);
		send_word(OP_ADD, 16'h7FFF);
		send_word(OP_ADD, 16'h8000);
		send_word(OP_ADD, 16'h0000);
		send_word(OP_ADD, 16'hFFFF);
		send_word(OP_ADD, 16'h0001);
		send_word(OP_CLEAR, 16'hFFFF);

		// fill every slot of a length-8 window, then shrink without a clear
		set_window(9'd8);
		send_word(OP_CLEAR, 16'h0000);
		for (int i = 0; i < 10; i++)
			send_word(OP_ADD, pick_sample());
		set_window(9'd3);
		for (int i = 0; i < 4; i++)
			send_word(OP_ADD, pick_sample());
		send_word(OP_CLEAR, pick_sample());

		for (int ph = 0; ph < 9; ph++) begin
			if (ph == 3) begin
				send_idle <= 64;
				recv_idle <= 23;
			end else if (ph == 6) begin
				send_idle <= 0;
				recv_idle <= 0;
			end
			case (ph)
				0:       begin len_sel = 9'd4;   words = 100; clear_odds = 25;  end
				1:       begin len_sel = 9'd1;   words = 60;  clear_odds = 20;  end
				2:       begin len_sel = 9'd0;   words = 60;  clear_odds = 20;  end
				3:       begin len_sel = 9'd256; words = 320; clear_odds = 500; end
				4:       begin len_sel = 9'd2;   words = 60;  clear_odds = 20;  end
				5:       begin len_sel = 9'd511; words = 300; clear_odds = 500; end
				6:       begin len_sel = 9'($urandom_range(3, 64));  words = 150; clear_odds = 60;  end
				7:       begin len_sel = 9'($urandom_range(1, 300)); words = 150; clear_odds = 200; end
				default: begin len_sel = 9'd17;  words = 150; clear_odds = 40;  end
			endcase
			// a new length always starts from an empty window
			set_window(len_sel);
			send_word(OP_CLEAR, pick_sample());
			for (int i = 0; i < words; i++)
				send_word(($urandom_range(clear_odds - 1) == 0) ? OP_CLEAR : OP_ADD, pick_sample());
		end

		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (200) @(posedge clk);
		if (mismatches == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule

@@ sliding_window_mean_variance.f @@
hw/rtl/swmv_pkg.sv
hw/rtl/swmv_ring.sv
hw/rtl/swmv_alu.sv
hw/rtl/sliding_window_mean_variance.sv
verif/swmv_checker.sv
verif/testbench.sv
